[rtl/core/dsls_pkg.sv]
package dsls_pkg;

  // Fixed field widths of the decode beat
  localparam int unsigned SRC_W  = 6;
  localparam int unsigned FPAIR_W = 4;
  localparam int unsigned REG_W  = 5;
  localparam int unsigned LAT_W  = 4;

  // Source register codes beyond the GPR numbers
  localparam logic [SRC_W-1:0] SRC_NONE = 6'd0;
  localparam logic [SRC_W-1:0] SRC_HI   = 6'd32;
  localparam logic [SRC_W-1:0] SRC_LO   = 6'd33;

  // Decoded instruction class
  typedef enum logic [1:0] {
    CLS_NORMAL  = 2'd0,
    CLS_SYSCALL = 2'd1,
    CLS_ILLEGAL = 2'd2
  } dsls_class_e;

  // One decode beat
  typedef struct packed {
    logic               machine_in_syscall;
    logic [1:0]         ins_class;
    logic [SRC_W-1:0]   source_a;
    logic [SRC_W-1:0]   source_b;
    logic [FPAIR_W-1:0] source_fpair;
    logic               writes_gpr;
    logic [REG_W-1:0]   dest_gpr;
    logic               writes_hi;
    logic               writes_lo;
    logic               writes_fpr;
    logic [REG_W-1:0]   dest_fpr;
    logic [LAT_W-1:0]   result_latency;
  } dsls_item_t;

  // Decision for one beat
  typedef struct packed {
    logic stall_fetch;
    logic issue_nop;
    logic enter_syscall;
  } dsls_result_t;

  // Counter raise request from the hazard check to the counter bank
  typedef struct packed {
    logic               en_gpr;
    logic               en_hi;
    logic               en_lo;
    logic               en_fpair;
    logic [REG_W-1:0]   gpr;
    logic [FPAIR_W-1:0] fpair;
    logic [LAT_W-1:0]   lat;
  } dsls_raise_t;

endpackage

[rtl/core/dsls_in_if.sv]
interface dsls_in_if;
  import dsls_pkg::*;

  logic               valid;
  logic               ready;
  logic               machine_in_syscall;
  logic [1:0]         ins_class;
  logic [SRC_W-1:0]   source_a;
  logic [SRC_W-1:0]   source_b;
  logic [FPAIR_W-1:0] source_fpair;
  logic               writes_gpr;
  logic [REG_W-1:0]   dest_gpr;
  logic               writes_hi;
  logic               writes_lo;
  logic               writes_fpr;
  logic [REG_W-1:0]   dest_fpr;
  logic [LAT_W-1:0]   result_latency;

  modport source (
    output valid, machine_in_syscall, ins_class, source_a, source_b, source_fpair,
           writes_gpr, dest_gpr, writes_hi, writes_lo, writes_fpr, dest_fpr,
           result_latency,
    input  ready
  );

  modport sink (
    input  valid, machine_in_syscall, ins_class, source_a, source_b, source_fpair,
           writes_gpr, dest_gpr, writes_hi, writes_lo, writes_fpr, dest_fpr,
           result_latency,
    output ready
  );
endinterface

[rtl/core/dsls_out_if.sv]
interface dsls_out_if;
  logic valid;
  logic ready;
  logic stall_fetch;
  logic issue_nop;
  logic enter_syscall;

  modport source (
    output valid, stall_fetch, issue_nop, enter_syscall,
    input  ready
  );

  modport sink (
    input  valid, stall_fetch, issue_nop, enter_syscall,
    output ready
  );
endinterface

[rtl/core/dsls_hazard_check.sv]
module dsls_hazard_check #(
  parameter int NUM_GPR   = 32,
  parameter int NUM_FPAIR = 16
) (
  input  dsls_pkg::dsls_item_t   item_i,
  input  logic [NUM_GPR-1:0]     gpr_busy_i,
  input  logic [NUM_FPAIR-1:0]   fpair_busy_i,
  input  logic [1:0]             hilo_busy_i,
  input  logic                   stall_flag_i,
  output dsls_pkg::dsls_result_t result_o,
  output dsls_pkg::dsls_raise_t  raise_o
);
  import dsls_pkg::*;

  logic gpr_a, gpr_b, busy_a, busy_b, busy_f, stall;

  // Busy lookup per source, one compare per scoreboard entry above zero
  always_comb begin
    gpr_a  = 1'b0;
    gpr_b  = 1'b0;
    busy_f = 1'b0;
    for (int i = 1; i < NUM_GPR; i++) begin
      if (int'(item_i.source_a) == i) gpr_a = gpr_busy_i[i];
      if (int'(item_i.source_b) == i) gpr_b = gpr_busy_i[i];
    end
    for (int i = 1; i < NUM_FPAIR; i++) begin
      if (int'(item_i.source_fpair) == i) busy_f = fpair_busy_i[i];
    end
  end

  // HI and LO codes shadow any GPR of the same number
  assign busy_a = (item_i.source_a == SRC_HI) ? hilo_busy_i[0] :
                  (item_i.source_a == SRC_LO) ? hilo_busy_i[1] : gpr_a;
  assign busy_b = (item_i.source_b == SRC_HI) ? hilo_busy_i[0] :
                  (item_i.source_b == SRC_LO) ? hilo_busy_i[1] : gpr_b;
  assign stall  = busy_a || busy_b || busy_f;

  // Decision and destination priority
  always_comb begin
    result_o       = '0;
    raise_o        = '0;
    raise_o.gpr    = item_i.dest_gpr;
    raise_o.fpair  = item_i.dest_fpr[REG_W-1:1];
    raise_o.lat    = item_i.result_latency;
    if (item_i.machine_in_syscall) begin
      result_o.stall_fetch = stall_flag_i;
    end else begin
      case (item_i.ins_class)
        CLS_NORMAL: begin
          if (stall) begin
            result_o.stall_fetch = 1'b1;
            result_o.issue_nop   = 1'b1;
          end else if (item_i.writes_gpr && (item_i.dest_gpr != '0)) begin
            raise_o.en_gpr = 1'b1;
          end else if (item_i.writes_hi) begin
            raise_o.en_hi = 1'b1;
          end else if (item_i.writes_lo) begin
            raise_o.en_lo = 1'b1;
          end else if (item_i.writes_fpr) begin
            raise_o.en_fpair = 1'b1;
          end
        end
        CLS_SYSCALL: begin
          result_o.enter_syscall = 1'b1;
        end
        default: begin
          result_o.issue_nop = 1'b1;
        end
      endcase
    end
  end
endmodule

[rtl/core/dsls_counter_bank.sv]
module dsls_counter_bank #(
  parameter int NUM_GPR   = 32,
  parameter int NUM_FPAIR = 16,
  parameter int WAIT_BITS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  dsls_pkg::dsls_raise_t raise_i,
  output logic [NUM_GPR-1:0]    gpr_busy_o,
  output logic [NUM_FPAIR-1:0]  fpair_busy_o,
  output logic [1:0]            hilo_busy_o
);
  import dsls_pkg::*;

  localparam int WaitMax = (1 << WAIT_BITS) - 1;
  localparam int CmpW    = (WAIT_BITS > LAT_W) ? WAIT_BITS : LAT_W;

  logic [WAIT_BITS-1:0] gpr_q   [NUM_GPR];
  logic [WAIT_BITS-1:0] gpr_d   [NUM_GPR];
  logic [WAIT_BITS-1:0] fpair_q [NUM_FPAIR];
  logic [WAIT_BITS-1:0] fpair_d [NUM_FPAIR];
  logic [WAIT_BITS-1:0] hilo_q  [2];
  logic [WAIT_BITS-1:0] hilo_d  [2];
  logic [1:0]           hilo_hit;
  logic [CmpW-1:0]      lat_w;
  logic [WAIT_BITS-1:0] lat_sat;

  // Latency clipped to what a counter holds
  assign lat_w   = CmpW'(raise_i.lat);
  assign lat_sat = (lat_w > CmpW'(WaitMax)) ? WAIT_BITS'(WaitMax) : WAIT_BITS'(lat_w);

  // Per entry: busy sample, decrement, then raise if the new latency is larger
  for (genvar g = 0; g < NUM_GPR; g++) begin : g_gpr
    logic [WAIT_BITS-1:0] dec;
    logic                 hit;
    assign dec           = gpr_q[g] - WAIT_BITS'(gpr_q[g] != '0);
    assign hit           = raise_i.en_gpr && (int'(raise_i.gpr) == g);
    assign gpr_d[g]      = (hit && (lat_sat > dec)) ? lat_sat : dec;
    assign gpr_busy_o[g] = gpr_q[g] != '0;
  end

  for (genvar g = 0; g < NUM_FPAIR; g++) begin : g_fpair
    logic [WAIT_BITS-1:0] dec;
    logic                 hit;
    assign dec             = fpair_q[g] - WAIT_BITS'(fpair_q[g] != '0);
    assign hit             = raise_i.en_fpair && (int'(raise_i.fpair) == g);
    assign fpair_d[g]      = (hit && (lat_sat > dec)) ? lat_sat : dec;
    assign fpair_busy_o[g] = fpair_q[g] != '0;
  end

  // Entry 0 is HI, entry 1 is LO
  assign hilo_hit = {raise_i.en_lo, raise_i.en_hi};

  for (genvar g = 0; g < 2; g++) begin : g_hilo
    logic [WAIT_BITS-1:0] dec;
    assign dec            = hilo_q[g] - WAIT_BITS'(hilo_q[g] != '0);
    assign hilo_d[g]      = (hilo_hit[g] && (lat_sat > dec)) ? lat_sat : dec;
    assign hilo_busy_o[g] = hilo_q[g] != '0;
  end

  // Counters advance once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GPR; i++) gpr_q[i] <= '0;
      for (int i = 0; i < NUM_FPAIR; i++) fpair_q[i] <= '0;
      for (int i = 0; i < 2; i++) hilo_q[i] <= '0;
    end else if (step_i) begin
      for (int i = 0; i < NUM_GPR; i++) gpr_q[i] <= gpr_d[i];
      for (int i = 0; i < NUM_FPAIR; i++) fpair_q[i] <= fpair_d[i];
      for (int i = 0; i < 2; i++) hilo_q[i] <= hilo_d[i];
    end
  end
endmodule

[rtl/core/decode_stage_latency_scoreboard.sv]
// Decode-stage hazard scoreboard. Each input beat is one decode cycle: every
// wait counter (one per GPR, one per FPR pair, HI and LO) is sampled as busy
// and decremented once per beat, and the beat's sources are checked against
// the busy samples; with no hazard, at most one destination counter is raised to the
// instruction's latency. The block takes one beat per clock while its output
// is not stalled. A beat lands in an input register, is resolved by the hazard
// check and counter update, and its result is registered in an output register.
// The counter update and the held stall flag are the loop-carried paths and
// close before the beat leaves the input register, so a stalled output only
// blocks the input once both registers are full.
module decode_stage_latency_scoreboard #(
  parameter int NUM_GPR   = 32,
  parameter int NUM_FPAIR = 16,
  parameter int WAIT_BITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsls_in_if.sink    in_i,
  dsls_out_if.source out_o
);
  import dsls_pkg::*;

  logic                 s1_valid_q;
  dsls_item_t           s1_q;
  logic                 out_valid_q;
  dsls_result_t         res_q;
  dsls_result_t         res;
  dsls_raise_t          raise;
  logic                 stall_flag_q;
  logic                 stall_flag_d;
  logic                 advance;
  logic                 in_fire;
  logic [NUM_GPR-1:0]   gpr_busy;
  logic [NUM_FPAIR-1:0] fpair_busy;
  logic [1:0]           hilo_busy;

  // Handshake: input register moves on when the output register is free or being read
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.machine_in_syscall <= in_i.machine_in_syscall;
      s1_q.ins_class          <= in_i.ins_class;
      s1_q.source_a           <= in_i.source_a;
      s1_q.source_b           <= in_i.source_b;
      s1_q.source_fpair       <= in_i.source_fpair;
      s1_q.writes_gpr         <= in_i.writes_gpr;
      s1_q.dest_gpr           <= in_i.dest_gpr;
      s1_q.writes_hi          <= in_i.writes_hi;
      s1_q.writes_lo          <= in_i.writes_lo;
      s1_q.writes_fpr         <= in_i.writes_fpr;
      s1_q.dest_fpr           <= in_i.dest_fpr;
      s1_q.result_latency     <= in_i.result_latency;
    end
  end

  // Hazard check on the registered beat
  dsls_hazard_check #(
    .NUM_GPR  (NUM_GPR),
    .NUM_FPAIR(NUM_FPAIR)
  ) u_check (
    .item_i      (s1_q),
    .gpr_busy_i  (gpr_busy),
    .fpair_busy_i(fpair_busy),
    .hilo_busy_i (hilo_busy),
    .stall_flag_i(stall_flag_q),
    .result_o    (res),
    .raise_o     (raise)
  );

  // Wait counters
  dsls_counter_bank #(
    .NUM_GPR  (NUM_GPR),
    .NUM_FPAIR(NUM_FPAIR),
    .WAIT_BITS(WAIT_BITS)
  ) u_counters (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .raise_i     (raise),
    .gpr_busy_o  (gpr_busy),
    .fpair_busy_o(fpair_busy),
    .hilo_busy_o (hilo_busy)
  );

  // Held stall flag: kept through a machine syscall, else the new stall
  assign stall_flag_d = s1_q.machine_in_syscall ? stall_flag_q : res.stall_fetch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_flag_q <= 1'b0;
    end else if (advance) begin
      stall_flag_q <= stall_flag_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.stall_fetch   = res_q.stall_fetch;
  assign out_o.issue_nop     = res_q.issue_nop;
  assign out_o.enter_syscall = res_q.enter_syscall;

  // An empty output register never blocks the input side
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input blocked while output register is empty");

  // A stall reported on a resolved beat is held in the flag
  a_stall_flag_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.stall_fetch) |=> stall_flag_q)
    else $error("stall flag not set after a stall");

  // A syscall entry is never also a replaced instruction
  a_syscall_no_nop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.enter_syscall && res_q.issue_nop))
    else $error("enter_syscall and issue_nop both set");

  // No counter is raised on a beat that stalls
  a_no_raise_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.stall_fetch |-> !(raise.en_gpr || raise.en_hi || raise.en_lo || raise.en_fpair))
    else $error("counter raised on a stalled beat");
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import dsls_pkg::*;

  localparam int NUM_GPR   = 32;
  localparam int NUM_FPAIR = 16;
  localparam int WAIT_BITS = 4;
  localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

  // HI/LO counter slots
  localparam int HI_IDX = 0;
  localparam int LO_IDX = 1;

  // Class encoding with no enum member; the block treats it as illegal
  localparam logic [1:0] CLS_UNUSED = 2'd3;

  // Small register pools so that random reads hit recent writes
  localparam int HOT_GPRS  = 6;
  localparam int HOT_PAIRS = 3;

  localparam int RANDOM_BEATS   = 1100;
  localparam int CALM_TAIL      = 120;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dsls_in_if  in_if ();
  dsls_out_if out_if ();

  decode_stage_latency_scoreboard dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Driven copies of the channel signals, known from time zero
  dsls_item_t in_beat   = '0;
  logic       in_valid  = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_fire   = 1'b0;

  assign in_if.valid              = in_valid;
  assign in_if.machine_in_syscall = in_beat.machine_in_syscall;
  assign in_if.ins_class          = in_beat.ins_class;
  assign in_if.source_a           = in_beat.source_a;
  assign in_if.source_b           = in_beat.source_b;
  assign in_if.source_fpair       = in_beat.source_fpair;
  assign in_if.writes_gpr         = in_beat.writes_gpr;
  assign in_if.dest_gpr           = in_beat.dest_gpr;
  assign in_if.writes_hi          = in_beat.writes_hi;
  assign in_if.writes_lo          = in_beat.writes_lo;
  assign in_if.writes_fpr         = in_beat.writes_fpr;
  assign in_if.dest_fpr           = in_beat.dest_fpr;
  assign in_if.result_latency     = in_beat.result_latency;
  assign out_if.ready             = out_ready;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  dsls_item_t   pending_beats[$];
  dsls_result_t expected_decisions[$];

  int mismatch_count = 0;
  int beats_checked  = 0;
  int stalls_seen    = 0;
  int nops_seen      = 0;
  int syscalls_seen  = 0;
  int held_beats     = 0;
  int send_gap       = 0;
  int recv_gap       = 0;
  int idle_cycles    = 0;

  // Scoreboard shadow state
  logic [WAIT_BITS-1:0] gpr_wait   [NUM_GPR];
  logic [WAIT_BITS-1:0] fpair_wait [NUM_FPAIR];
  logic [WAIT_BITS-1:0] hilo_wait  [2];
  logic                 held_stall;
  logic [NUM_GPR-1:0]   gpr_busy;
  logic [NUM_FPAIR-1:0] fpair_busy;
  logic [1:0]           hilo_busy;

  function automatic logic source_busy(logic [SRC_W-1:0] s);
    if (s == SRC_NONE) return 1'b0;
    if (s == SRC_HI) return hilo_busy[HI_IDX];
    if (s == SRC_LO) return hilo_busy[LO_IDX];
    if (s < NUM_GPR) return gpr_busy[s];
    return 1'b0;
  endfunction

  // One decode cycle: sample busy, count down, then decide and maybe raise
  function automatic dsls_result_t predict_decode(dsls_item_t b);
    dsls_result_t         r;
    logic                 hazard;
    logic [WAIT_BITS-1:0] lat;
    logic [FPAIR_W-1:0]   pair;
    r = '0;
    for (int i = 0; i < NUM_GPR; i++) begin
      gpr_busy[i] = gpr_wait[i] != '0;
      if (gpr_busy[i]) gpr_wait[i] = gpr_wait[i] - 1'b1;
    end
    for (int i = 0; i < NUM_FPAIR; i++) begin
      fpair_busy[i] = fpair_wait[i] != '0;
      if (fpair_busy[i]) fpair_wait[i] = fpair_wait[i] - 1'b1;
    end
    for (int i = 0; i < 2; i++) begin
      hilo_busy[i] = hilo_wait[i] != '0;
      if (hilo_busy[i]) hilo_wait[i] = hilo_wait[i] - 1'b1;
    end

    // machine busy with a syscall: counters only, stall flag repeats
    if (b.machine_in_syscall) begin
      r.stall_fetch = held_stall;
      return r;
    end
    held_stall = 1'b0;

    if (b.ins_class == CLS_SYSCALL) begin
      r.enter_syscall = 1'b1;
      return r;
    end
    if (b.ins_class != CLS_NORMAL) begin
      r.issue_nop = 1'b1;
      return r;
    end

    hazard = source_busy(b.source_a) || source_busy(b.source_b);
    if (b.source_fpair != '0 && b.source_fpair < NUM_FPAIR && fpair_busy[b.source_fpair])
      hazard = 1'b1;
    if (hazard) begin
      held_stall    = 1'b1;
      r.stall_fetch = 1'b1;
      r.issue_nop   = 1'b1;
      return r;
    end

    // single destination, first match wins; counter only grows
    lat  = (b.result_latency > WAIT_MAX) ? WAIT_MAX : b.result_latency;
    pair = b.dest_fpr[REG_W-1:1];
    if (b.writes_gpr && b.dest_gpr != '0) begin
      if (lat > gpr_wait[b.dest_gpr]) gpr_wait[b.dest_gpr] = lat;
    end else if (b.writes_hi) begin
      if (lat > hilo_wait[HI_IDX]) hilo_wait[HI_IDX] = lat;
    end else if (b.writes_lo) begin
      if (lat > hilo_wait[LO_IDX]) hilo_wait[LO_IDX] = lat;
    end else if (b.writes_fpr) begin
      if (lat > fpair_wait[pair]) fpair_wait[pair] = lat;
    end
    return r;
  endfunction

  function automatic dsls_item_t decode_beat(
    logic sys, logic [1:0] cls, logic [SRC_W-1:0] sa, logic [SRC_W-1:0] sb,
    logic [FPAIR_W-1:0] fp, logic wg, logic [REG_W-1:0] dg, logic wh, logic wl,
    logic wf, logic [REG_W-1:0] df, logic [LAT_W-1:0] lat);
    dsls_item_t b;
    b = '{sys, cls, sa, sb, fp, wg, dg, wh, wl, wf, df, lat};
    return b;
  endfunction

  function automatic logic [SRC_W-1:0] random_source();
    int unsigned      roll;
    logic [SRC_W-1:0] s;
    roll = $urandom_range(0, 99);
    if (roll < 15)      s = SRC_NONE;
    else if (roll < 65) s = $urandom_range(1, HOT_GPRS);
    else if (roll < 75) s = roll[0] ? SRC_HI : SRC_LO;
    else if (roll < 95) s = $urandom_range(0, 33);
    else                s = $urandom_range(34, 63);
    return s;
  endfunction

  // Mostly write/read traffic on a few registers, with syscalls and junk mixed in
  function automatic dsls_item_t random_beat();
    dsls_item_t  b;
    int unsigned roll;
    b.machine_in_syscall = $urandom_range(0, 9) == 0;
    roll = $urandom_range(0, 99);
    if (roll < 80)      b.ins_class = CLS_NORMAL;
    else if (roll < 87) b.ins_class = CLS_SYSCALL;
    else if (roll < 94) b.ins_class = CLS_ILLEGAL;
    else                b.ins_class = CLS_UNUSED;
    b.source_a = random_source();
    b.source_b = random_source();
    roll = $urandom_range(0, 99);
    if (roll < 30)      b.source_fpair = '0;
    else if (roll < 80) b.source_fpair = $urandom_range(1, HOT_PAIRS);
    else                b.source_fpair = $urandom_range(0, 15);
    b.writes_gpr = $urandom_range(0, 99) < 60;
    b.dest_gpr   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, HOT_GPRS)
                                              : $urandom_range(0, 31);
    b.writes_hi  = $urandom_range(0, 3) == 0;
    b.writes_lo  = $urandom_range(0, 3) == 0;
    b.writes_fpr = $urandom_range(0, 2) == 0;
    b.dest_fpr   = ($urandom_range(0, 9) < 6) ? $urandom_range(2, 2 * HOT_PAIRS + 1)
                                              : $urandom_range(0, 31);
    b.result_latency = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 15);
    return b;
  endfunction

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver and sink ready, both moved at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_fire) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_beat  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end

      if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (pending_beats.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
        recv_gap  <= $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each input beat, check each output beat
  always @(posedge clk_i or negedge rst_ni) begin
    dsls_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GPR; i++) gpr_wait[i] = '0;
      for (int i = 0; i < NUM_FPAIR; i++) fpair_wait[i] = '0;
      for (int i = 0; i < 2; i++) hilo_wait[i] = '0;
      held_stall = 1'b0;
      in_fire   <= 1'b0;
    end else begin
      in_fire <= in_valid && in_if.ready;
      if (in_valid && in_if.ready) begin
        if (in_beat.machine_in_syscall) held_beats++;
        expected_decisions.push_back(predict_decode(in_beat));
      end
      if (out_if.valid && out_ready) begin
        if (expected_decisions.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %b%b%b", $time,
                   out_if.stall_fetch, out_if.issue_nop, out_if.enter_syscall);
          mismatch_count++;
        end else begin
          want = expected_decisions.pop_front();
          check_field("stall_fetch", want.stall_fetch, out_if.stall_fetch);
          check_field("issue_nop", want.issue_nop, out_if.issue_nop);
          check_field("enter_syscall", want.enter_syscall, out_if.enter_syscall);
          beats_checked++;
          if (want.stall_fetch) stalls_seen++;
          if (want.issue_nop) nops_seen++;
          if (want.enter_syscall) syscalls_seen++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_if.ready) || (out_if.valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // directed: write r31, then hit it from both sources and while held
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, 0, 0, 1, 31, 0, 0, 0, 0, 15));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(decode_beat(1, CLS_NORMAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, 31, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(decode_beat(0, CLS_SYSCALL, 31, 31, 0, 1, 9, 1, 1, 1, 9, 15));
    pending_beats.push_back(decode_beat(1, CLS_ILLEGAL, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // priority: HI over LO and FPR, then LO over FPR, then GPR zero falls to FPR
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, 0, 0, 0, 0, 1, 1, 1, 31, 15));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, SRC_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, 0, 0, 0, 0, 0, 1, 1, 31, 9));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, SRC_LO, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, 0, 0, 1, 0, 0, 0, 1, 31, 15));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, 0, 15, 0, 0, 0, 0, 0, 0, 0));
    // illegal classes, out of range sources, zero and lower latencies
    pending_beats.push_back(decode_beat(0, CLS_ILLEGAL, 31, 31, 15, 1, 3, 0, 0, 0, 0, 15));
    pending_beats.push_back(decode_beat(0, CLS_UNUSED, 0, 0, 0, 1, 3, 0, 0, 0, 0, 15));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, '1, 6'd34, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, 0, 0, 1, 5, 0, 0, 0, 0, 0));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, 0, 0, 1, 31, 0, 0, 0, 0, 1));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, 0, 0, 1, 7, 0, 0, 0, 0, 1));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(decode_beat(1, CLS_UNUSED, '1, '1, '1, 1, '1, 1, 1, 1, '1, '1));
    pending_beats.push_back(decode_beat(0, CLS_NORMAL, 0, 0, 0, 0, 0, 0, 0, 1, 0, 4));
    for (int i = 0; i < RANDOM_BEATS; i++) pending_beats.push_back(random_beat());

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_beats.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_decisions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d decode beats (%0d during a held syscall)", beats_checked,
             held_beats);
    $display("  decisions: %0d stalls, %0d NOPs, %0d syscall entries, %0d mismatches",
             stalls_seen, nops_seen, syscalls_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[decode_stage_latency_scoreboard.f]
rtl/core/dsls_pkg.sv
rtl/core/dsls_in_if.sv
rtl/core/dsls_out_if.sv
rtl/core/dsls_hazard_check.sv
rtl/core/dsls_counter_bank.sv
rtl/core/decode_stage_latency_scoreboard.sv
tb/tb_top.sv
